>>> hdl/lkv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU key-value store.
// No dependencies; imported by every other file in hdl/.
package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_RESET   = 16;
  localparam int CFG_W       = 5;
  localparam int DATA_W      = 32;

  // Request type codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  // Value returned by a get that misses
  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] value_out;
    logic                     evicted;
  } rsp_t;

  // One cache entry as handed from cell to cell
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

endpackage

>>> hdl/lkv_cell.sv
`timescale 1ns / 1ps
// One storage cell of the recency chain: key, value and valid mark.
// Depends on lkv_pkg.
module lkv_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lkv_pkg::entry_t                  prev_i,
  input  logic                             shift_en_i,
  input  logic signed [lkv_pkg::DATA_W-1:0] cmp_key_i,
  output lkv_pkg::entry_t                  ent_o,
  output logic                             match_o
);
  import lkv_pkg::*;

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] value_r;

  // Valid mark follows the neighbor on a shift
  always_comb begin
    valid_nxt = shift_en_i ? prev_i.valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (shift_en_i) begin
      key_r   <= prev_i.key;
      value_r <= prev_i.value;
    end
  end

  assign ent_o.valid = valid_r;
  assign ent_o.key   = key_r;
  assign ent_o.value = value_r;
  assign match_o     = valid_r && (key_r == cmp_key_i);

endmodule

>>> hdl/lkv_array.sv
`timescale 1ns / 1ps
// Chain of lkv_cell ordered by recency (cell 0 = most recent) plus hit encode.
// Depends on lkv_pkg and lkv_cell.
module lkv_array #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  parameter int IW      = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [lkv_pkg::DATA_W-1:0] cmp_key_i,
  input  logic                              shift_go_i,
  input  logic [IW-1:0]                     shift_lim_i,
  input  lkv_pkg::entry_t                   front_i,
  output logic                              hit_o,
  output logic [IW-1:0]                     hit_idx_o,
  output logic signed [lkv_pkg::DATA_W-1:0] hit_value_o
);
  import lkv_pkg::*;

  entry_t             ent   [ENTRIES];
  entry_t             prev  [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] shift_en;

  // Cells up to the shift limit take their neighbor's entry; cell 0 takes the front
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev[g] = front_i;
    end else begin : g_body
      assign prev[g] = ent[g-1];
    end

    assign shift_en[g] = shift_go_i && (IW'(g) <= shift_lim_i);

    lkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .prev_i     (prev[g]),
      .shift_en_i (shift_en[g]),
      .cmp_key_i  (cmp_key_i),
      .ent_o      (ent[g]),
      .match_o    (match[g])
    );
  end

  // Keys are unique, so at most one match: OR-encode index and value
  always_comb begin
    hit_o       = 1'b0;
    hit_idx_o   = '0;
    hit_value_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_o       = 1'b1;
        hit_idx_o   = hit_idx_o | IW'(i);
        hit_value_o = hit_value_o | ent[i].value;
      end
    end
  end

endmodule

>>> hdl/lru_key_value_store_unit.sv
`timescale 1ns / 1ps
// Fully associative LRU key-value store, top level: control, capacity, result register.
// Depends on lkv_pkg and lkv_array.
//
// Usage:
//   in_*  : request channel (valid/ready), in_req = {req_type, key, value_in}.
//           req_type REQ_GET looks a key up, REQ_SET inserts or updates it.
//   out_* : response channel (valid/ready), out_rsp = {found, value_out, evicted}.
//           Exactly one response per request, in request order.
//   cfg_* : capacity write (valid/ready, always ready). Taken only while the
//           store holds no entries; values above ENTRIES saturate to ENTRIES.
// Timing: a request is compared against all cells in the cycle after it is
// accepted, and the recency chain shifts in the update state, which also
// loads the response register. The next request is taken in the shift
// cycle, so a new request can be accepted while the last one commits.
// Back-pressure: while a response waits in the output register, the shift of
// the following request holds until out_ready frees the register.
// Reset (rst_n low, synchronous): all valid marks clear, capacity returns to
// min(16, ENTRIES); no clearing pass is needed.
module lru_key_value_store_unit #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lkv_pkg::req_t                  in_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lkv_pkg::rsp_t                  out_rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lkv_pkg::CFG_W-1:0]      cfg_capacity
);
  import lkv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = (CFG_W > CW) ? CFG_W : CW;
  localparam int CAP_INIT = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

  state_t                   state_r;
  state_t                   state_nxt;
  req_t                     req_r;
  logic                     hit_r;
  logic [IW-1:0]            hit_idx_r;
  logic signed [DATA_W-1:0] hit_value_r;
  logic [CW-1:0]            used_r;
  logic [CW-1:0]            used_nxt;
  logic [CW-1:0]            cap_r;
  logic [CW-1:0]            cap_nxt;
  logic                     out_valid_r;
  rsp_t                     out_rsp_r;

  logic                     arr_hit;
  logic [IW-1:0]            arr_hit_idx;
  logic signed [DATA_W-1:0] arr_hit_value;

  logic                     out_free;
  logic                     commit;
  logic                     in_acc;
  logic                     is_set;
  logic                     full;
  logic                     cap_zero;
  logic [CW-1:0]            used_dec;
  logic                     shift_go;
  logic [IW-1:0]            shift_lim;
  entry_t                   front;
  rsp_t                     rsp;
  logic [MW-1:0]            cfg_ext;

  // Handshake
  assign out_free  = !out_valid_r || out_ready;
  assign commit    = (state_r == ST_UPDATE) && out_free;
  assign in_ready  = (state_r == ST_IDLE) || commit;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit) state_nxt = in_acc ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the update step: chain shift control and response
  always_comb begin
    is_set   = (req_r.req_type == REQ_SET);
    full     = (used_r >= cap_r);
    cap_zero = (cap_r == '0);
    used_dec = used_r - CW'(1);

    shift_go = 1'b0;
    used_nxt = used_r;
    case (state_r)
      ST_UPDATE: begin
        shift_go = commit && (is_set ? !cap_zero : hit_r);
        if (shift_go && is_set && !hit_r && !full) used_nxt = used_r + CW'(1);
      end
      default: begin
        shift_go = 1'b0;
      end
    endcase

    // Hit: rotate the hit entry to the front; insert: shift into the first free cell, or through the LRU slot when full
    if (hit_r) begin
      shift_lim = hit_idx_r;
    end else if (full) begin
      shift_lim = used_dec[IW-1:0];
    end else begin
      shift_lim = used_r[IW-1:0];
    end

    front.valid = 1'b1;
    front.key   = req_r.key;
    front.value = is_set ? req_r.value_in : hit_value_r;

    rsp.found     = hit_r;
    rsp.value_out = is_set ? '0 : (hit_r ? hit_value_r : MISS_VALUE);
    rsp.evicted   = is_set && !cap_zero && !hit_r && full;
  end

  // Capacity register: saturate, and only take writes while empty
  always_comb begin
    cfg_ext = MW'(cfg_capacity);
    cap_nxt = cap_r;
    if (cfg_valid && cfg_ready && (used_r == '0)) begin
      cap_nxt = (cfg_ext > MW'(ENTRIES)) ? CW'(ENTRIES) : cfg_ext[CW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      cap_r       <= CW'(CAP_INIT);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      cap_r   <= cap_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_req;
    end
    if (state_r == ST_LOOKUP) begin
      hit_r       <= arr_hit;
      hit_idx_r   <= arr_hit_idx;
      hit_value_r <= arr_hit_value;
    end
    if (commit) begin
      out_rsp_r <= rsp;
    end
  end

  lkv_array #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_array (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmp_key_i   (req_r.key),
    .shift_go_i  (shift_go),
    .shift_lim_i (shift_lim),
    .front_i     (front),
    .hit_o       (arr_hit),
    .hit_idx_o   (arr_hit_idx),
    .hit_value_o (arr_hit_value)
  );

`ifndef SYNTHESIS
  // Entries in use never exceed the capacity
  a_used_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= cap_r)
    else $error("used count above capacity");

  // Requests are only taken when idle or while committing the previous one
  a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (state_r == ST_IDLE || state_r == ST_UPDATE))
    else $error("request accepted mid-lookup");

  // The compare cycle is always followed by the update cycle
  a_lookup_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOKUP |=> state_r == ST_UPDATE)
    else $error("lookup not followed by update");

  // Capacity holds while the store is not empty
  a_cap_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != '0) |=> $stable(cap_r))
    else $error("capacity changed while entries in use");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_store_unit: random get/set requests
// against an in-bench LRU predictor, with random idling and back-pressure.
// Depends on lkv_pkg and the RTL under hdl/.
module tb;
  import lkv_pkg::*;

  localparam int ENTRIES  = ENTRIES_DEF;
  localparam int POOL_LEN = 20;
  localparam int N_RANDOM = 1400;

  logic clk;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  req_t             in_req = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  rsp_t             out_rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_capacity = '0;

  lru_key_value_store_unit #(.ENTRIES(ENTRIES)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp(out_rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_capacity(cfg_capacity)
  );

  // Requests waiting to be offered, responses owed by the store
  req_t req_backlog[$];
  rsp_t rsp_due[$];

  // Predicted store contents
  logic signed [DATA_W-1:0] slot_key[ENTRIES];
  logic signed [DATA_W-1:0] slot_val[ENTRIES];
  logic                     slot_valid[ENTRIES];
  int                       slot_rank[ENTRIES];
  int                       cap_now;

  // Stimulus shaping
  logic signed [DATA_W-1:0] key_pool[POOL_LEN];
  int pool_span;
  int send_idle_pct;
  int recv_idle_pct;

  // Bookkeeping
  int n_mismatch;
  int n_stray;
  int n_resp;
  int n_hits;
  int n_evict;
  int n_gets;
  int n_sets;
  int n_cfg;
  int n_cfg_taken;
  int hold_left;
  logic hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fixed ceiling on run time
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i]) n++;
    return n;
  endfunction

  // Slot s becomes most recent; valid entries younger than limit age by one
  function automatic void move_to_front(int s, int limit);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && i != s && slot_rank[i] < limit) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic rsp_t lru_access(req_t r);
    rsp_t res;
    int   hit;
    int   slot;
    int   worst;
    res = '0;
    hit = -1;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && slot_valid[i] && slot_key[i] == r.key) hit = i;

    if (r.req_type == REQ_GET) begin
      if (hit >= 0) begin
        res.found = 1'b1;
        res.value_out = slot_val[hit];
        move_to_front(hit, slot_rank[hit]);
      end else begin
        res.value_out = MISS_VALUE;
      end
      return res;
    end

    // Zero capacity: sets are dropped
    if (cap_now == 0) return res;

    if (hit >= 0) begin
      res.found = 1'b1;
      slot_val[hit] = r.value_in;
      move_to_front(hit, slot_rank[hit]);
      return res;
    end

    if (used_count() >= cap_now) begin
      // full: evict the oldest entry
      worst = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_valid[i] && (slot < 0 || slot_rank[i] > worst)) begin
          slot = i;
          worst = slot_rank[i];
        end
      if (slot < 0) return res;
      slot_valid[slot] = 1'b0;
      res.evicted = 1'b1;
    end else begin
      // lowest free slot
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && !slot_valid[i]) slot = i;
      if (slot < 0) return res;
    end
    slot_key[slot] = r.key;
    slot_val[slot] = r.value_in;
    slot_valid[slot] = 1'b1;
    move_to_front(slot, ENTRIES + 1);
    return res;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_due.push_back(lru_access(in_req));
        if (in_req.req_type == REQ_GET) n_gets++;
        else n_sets++;
      end
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_req <= req_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_resp++;
        if (out_rsp.found && !out_rsp.evicted) n_hits++;
        if (out_rsp.evicted) n_evict++;
        if (rsp_due.size() == 0) begin
          n_stray++;
          if (n_mismatch + n_stray <= 10)
            $display("%0t: stray response: found=%0b value=%0d evicted=%0b",
                     $realtime, out_rsp.found, out_rsp.value_out, out_rsp.evicted);
        end else begin
          want = rsp_due.pop_front();
          if (out_rsp.found !== want.found || out_rsp.value_out !== want.value_out ||
              out_rsp.evicted !== want.evicted) begin
            n_mismatch++;
            if (n_mismatch + n_stray <= 10)
              $display("%0t: mismatch: expected %0b/%0d/%0b, got %0b/%0d/%0b",
                       $realtime, want.found, want.value_out, want.evicted,
                       out_rsp.found, out_rsp.value_out, out_rsp.evicted);
          end
        end
      end
      // one long hold-off to back the store up, otherwise random stalls
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && n_resp >= 200) begin
        hold_left <= 80;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic queue_req(input logic t, input logic signed [DATA_W-1:0] k,
                           input logic signed [DATA_W-1:0] v);
    req_t r;
    r.req_type = t;
    r.key = k;
    r.value_in = v;
    req_backlog.push_back(r);
  endtask

  // Mostly keys from a small pool so hits and evictions both happen
  function automatic req_t make_req();
    req_t r;
    r.req_type = 1'($urandom_range(0, 1));
    r.value_in = $urandom;
    if ($urandom_range(0, 99) < 80) r.key = key_pool[$urandom_range(0, pool_span - 1)];
    else r.key = $urandom;
    return r;
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) req_backlog.push_back(make_req());
  endtask

  // Wait until every request went out and every response came back
  task automatic wait_idle();
    @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || rsp_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_capacity <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg++;
    // only taken while the store is empty; saturates at ENTRIES
    if (used_count() == 0) begin
      cap_now = (v > ENTRIES) ? ENTRIES : v;
      n_cfg_taken++;
    end
    cfg_valid <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_valid[i] = 1'b0;
      slot_rank[i] = 0;
    end
    cap_now = CAP_RESET > ENTRIES ? ENTRIES : CAP_RESET;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_LEN; i++) key_pool[i] = $urandom;
    pool_span = POOL_LEN;
    n_mismatch = 0;
    n_stray = 0;
    n_resp = 0;
    n_hits = 0;
    n_evict = 0;
    n_gets = 0;
    n_sets = 0;
    n_cfg = 0;
    n_cfg_taken = 0;
    send_idle_pct = 19;
    recv_idle_pct = 64;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store after reset: every get misses
    @(negedge clk);
    queue_req(REQ_GET, 32'sh0000_0000, 32'sh0);
    queue_req(REQ_GET, 32'sh8000_0000, 32'sh0);
    queue_req(REQ_GET, 32'sh7fff_ffff, -32'sd1);
    queue_req(REQ_GET, -32'sd1, 32'sh0);
    wait_idle();

    // capacity zero: sets are dropped, store stays empty
    write_capacity(5'd0);
    @(negedge clk);
    queue_req(REQ_SET, 32'sh8000_0000, 32'sh7fff_ffff);
    queue_req(REQ_SET, 32'sh7fff_ffff, 32'sh8000_0000);
    queue_req(REQ_GET, 32'sh8000_0000, 32'sh0);
    queue_req(REQ_GET, 32'sh7fff_ffff, 32'sh0);
    wait_idle();

    // oversize capacity saturates
    write_capacity(5'd31);
    @(negedge clk);
    queue_req(REQ_GET, 32'sh0000_0001, 32'sh0);
    wait_idle();

    // working capacity for the rest of the run
    write_capacity(CFG_W'($urandom_range(1, ENTRIES)));
    pool_span = (cap_now + 3 < POOL_LEN) ? cap_now + 3 : POOL_LEN;
    @(negedge clk);
    queue_req(REQ_SET, 32'sh8000_0000, 32'sh7fff_ffff);
    queue_req(REQ_SET, 32'sh7fff_ffff, 32'sh8000_0000);
    queue_req(REQ_SET, 32'sh0000_0000, 32'sh0000_0000);
    queue_req(REQ_SET, -32'sd1, -32'sd1);
    queue_req(REQ_GET, 32'sh8000_0000, 32'sh0);
    queue_req(REQ_GET, 32'sh7fff_ffff, 32'sh0);
    queue_req(REQ_GET, 32'sh0000_0000, 32'sh0);
    queue_req(REQ_GET, -32'sd1, 32'sh0);
    queue_req(REQ_SET, -32'sd1, 32'sh1234_5678);
    queue_req(REQ_GET, -32'sd1, 32'sh0);
    wait_idle();

    // store no longer empty: these writes must be ignored
    write_capacity(5'd0);
    write_capacity(CFG_W'($urandom_range(0, 31)));

    // phase 1: sender idles lightly, receiver heavily; pause halfway
    @(negedge clk);
    queue_random(N_RANDOM / 6);
    wait_idle();
    @(negedge clk);
    queue_random(N_RANDOM / 3 - N_RANDOM / 6);
    wait_idle();
    write_capacity(5'd31);

    // phase 2: the other way round
    send_idle_pct = 64;
    recv_idle_pct = 19;
    @(negedge clk);
    queue_random(N_RANDOM / 3);
    wait_idle();
    write_capacity(5'd1);

    // phase 3: full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    queue_random(N_RANDOM - 2 * (N_RANDOM / 3));
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Ran %0d gets and %0d sets; %0d responses, %0d hits, %0d evictions.",
             n_gets, n_sets, n_resp, n_hits, n_evict);
    $display("Capacity writes: %0d, taken: %0d, working capacity %0d.",
             n_cfg, n_cfg_taken, cap_now);
    if (n_mismatch == 0 && n_stray == 0 && rsp_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
